// File: rtl/urlb_pkg.sv
// Shared constants, types and helpers for the UART receive line buffer.
`timescale 1ns / 1ps
`default_nettype none
package urlb_pkg;

    // Ring depth default
    localparam int RING_DEPTH_DEF = 256;

    // Destination size register
    localparam int          SIZE_W     = 7;
    localparam int          USED_W     = 6;
    localparam logic [6:0]  SIZE_LIMIT = 7'd64;
    localparam logic [6:0]  SIZE_RESET = 7'd64;

    // APB register map
    localparam int          APB_ADDR_W   = 3;
    localparam int          APB_DATA_W   = 32;
    localparam logic        REG_SIZE_IDX = 1'b0;

    // Request kinds carried on s_tuser
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Line terminators
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Memory strobes from the controller to the ring memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    function automatic logic is_term(input logic [7:0] b);
        is_term = (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage
`default_nettype wire

// File: rtl/urlb_ram.sv
// Byte ring storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module urlb_ram #(
    parameter int RING_DEPTH = urlb_pkg::RING_DEPTH_DEF,
    localparam int PTR_W     = $clog2(RING_DEPTH)
) (
    input  wire logic               clk,
    input  wire urlb_pkg::mem_ctl_t mem_ctl,
    input  wire logic [PTR_W-1:0]   wr_addr,
    input  wire logic [7:0]         wr_data,
    input  wire logic [PTR_W-1:0]   rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data valid in the cycle after the strobe and held until the next
    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/urlb_cfg.sv
// APB register block holding the destination size.
`timescale 1ns / 1ps
`default_nettype none
module urlb_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [urlb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [urlb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [urlb_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    output logic [urlb_pkg::SIZE_W-1:0]              out_buffer_size
);

    logic [urlb_pkg::SIZE_W-1:0] size_reg;
    logic                        sel_size;

    // Word decode ignores the byte offset
    assign sel_size = (paddr[2] == urlb_pkg::REG_SIZE_IDX);
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= urlb_pkg::SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_size)
        begin
            size_reg <= pwdata[urlb_pkg::SIZE_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (sel_size)
        begin
            prdata = {{(urlb_pkg::APB_DATA_W - urlb_pkg::SIZE_W){1'b0}}, size_reg};
        end
    end

    assign out_buffer_size = size_reg;

endmodule
`default_nettype wire

// File: rtl/urlb_ctrl.sv
// Ring pointers, terminator count, line walk sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
module urlb_ctrl #(
    parameter int RING_DEPTH = urlb_pkg::RING_DEPTH_DEF,
    localparam int PTR_W     = $clog2(RING_DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [urlb_pkg::SIZE_W-1:0]   out_buffer_size,
    // request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic [0:0]                    s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    // ring memory
    output urlb_pkg::mem_ctl_t                 mem_ctl,
    output logic [PTR_W-1:0]                   wr_addr,
    output logic [7:0]                         wr_data,
    output logic [PTR_W-1:0]                   rd_addr,
    input  wire logic [7:0]                    rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DATA = 3'b010,
        ST_SWAL = 3'b100
    } state_t;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    state_t                       state_reg, state_next;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [PTR_W-1:0]             rp_reg, rp_next;
    logic [PTR_W-1:0]             tc_reg, tc_next;
    logic [urlb_pkg::USED_W-1:0]  used_reg, used_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [7:0]                   pend_char_reg, pend_char_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_char_reg, out_char_next;
    logic                         out_cv_reg, out_cv_next;
    logic                         out_rdy_reg, out_rdy_next;
    logic                         out_last_reg, out_last_next;

    logic                         out_free;
    logic                         in_fire;
    logic [urlb_pkg::SIZE_W-1:0]  size_sat;
    logic                         keep;
    logic                         load_out;
    logic [7:0]                   o_char;
    logic                         o_cv;
    logic                         o_rdy;
    logic                         o_last;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign size_sat = (out_buffer_size > urlb_pkg::SIZE_LIMIT) ? urlb_pkg::SIZE_LIMIT
                                                               : out_buffer_size;
    assign keep     = ({1'b0, used_reg} + 1'b1) < size_sat;
    assign wr_addr  = wp_reg;
    assign wr_data  = s_tdata;
    assign rd_addr  = rp_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        tc_next         = tc_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        mem_ctl         = '0;
        load_out        = 1'b0;
        o_char          = '0;
        o_cv            = 1'b0;
        o_rdy           = 1'b0;
        o_last          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] == urlb_pkg::FUNC_PUSH)
                    begin
                        // store unless full; one slot stays free
                        if (ptr_inc(wp_reg) != rp_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wp_next       = ptr_inc(wp_reg);
                            if (urlb_pkg::is_term(s_tdata))
                            begin
                                tc_next = tc_reg + 1'b1;
                            end
                        end
                    end
                    else if (size_sat != '0 && tc_reg != '0)
                    begin
                        // a full line is in the ring: start the walk
                        mem_ctl.rd_en   = 1'b1;
                        rp_next         = ptr_inc(rp_reg);
                        used_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_DATA;
                    end
                    else
                    begin
                        // not ready
                        load_out = 1'b1;
                        o_last   = 1'b1;
                    end
                end
            end

            ST_DATA:
            begin
                if (urlb_pkg::is_term(rd_data))
                begin
                    if (rp_reg != wp_reg)
                    begin
                        // look at the byte after the terminator
                        tc_next       = tc_reg - 1'b1;
                        mem_ctl.rd_en = 1'b1;
                        state_next    = ST_SWAL;
                    end
                    else if (out_free)
                    begin
                        tc_next    = tc_reg - 1'b1;
                        load_out   = 1'b1;
                        o_char     = pend_valid_reg ? pend_char_reg : 8'h00;
                        o_cv       = pend_valid_reg;
                        o_rdy      = 1'b1;
                        o_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!(keep && pend_valid_reg) || out_free)
                begin
                    // held character goes out once a newer one is kept
                    if (keep)
                    begin
                        if (pend_valid_reg)
                        begin
                            load_out = 1'b1;
                            o_char   = pend_char_reg;
                            o_cv     = 1'b1;
                            o_rdy    = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_char_next  = rd_data;
                        used_next       = used_reg + 1'b1;
                    end
                    mem_ctl.rd_en = 1'b1;
                    rp_next       = ptr_inc(rp_reg);
                end
            end

            ST_SWAL:
            begin
                if (out_free)
                begin
                    // CRLF, or any other pair of terminators, counts as one line end
                    if (urlb_pkg::is_term(rd_data))
                    begin
                        rp_next = ptr_inc(rp_reg);
                        tc_next = tc_reg - 1'b1;
                    end
                    load_out   = 1'b1;
                    o_char     = pend_valid_reg ? pend_char_reg : 8'h00;
                    o_cv       = pend_valid_reg;
                    o_rdy      = 1'b1;
                    o_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_cv_next    = out_cv_reg;
        out_rdy_next   = out_rdy_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = o_char;
            out_cv_next    = o_cv;
            out_rdy_next   = o_rdy;
            out_last_next  = o_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            tc_reg         <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            tc_reg         <= tc_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_cv_reg    <= out_cv_next;
        out_rdy_reg   <= out_rdy_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_rdy_reg, out_cv_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: rtl/uart_rx_line_buffer.sv
// Top level of the UART receive line buffer.
//
// Requests enter on the s_ stream: s_tuser selects push (0) or read-line (1),
// s_tdata carries the received byte for a push. Pushes store into a byte ring
// of RING_DEPTH entries, one slot kept free; a push into a full ring is dropped
// and gives no result. A read-line gives results on the m_ stream: m_tdata is
// a kept character, m_tuser flags char_valid and line_ready, m_tlast closes
// the request. With no complete line (or size zero) one not-ready result is
// given and nothing is consumed. out_buffer_size sits at APB address 0.
// The ring memory has a registered read port. The walk reads one byte per
// cycle while the receiver takes results, and reads one more byte when a
// byte follows the terminator. A running count of stored terminators
// answers the line-present test at once. Reset empties the ring and sets
// the size to 64. A stalled receiver holds the walk at its next result;
// requests are taken only between reads.
`timescale 1ns / 1ps
`default_nettype none
module uart_rx_line_buffer #(
    parameter int RING_DEPTH = urlb_pkg::RING_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [urlb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [urlb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [urlb_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    // request stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                          s_tuser,   // [0] func
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // [7:0] line_char
    output logic [1:0]                               m_tuser,   // [0] char_valid, [1] line_ready
    output logic                                     m_tlast
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [urlb_pkg::SIZE_W-1:0] out_buffer_size;
    urlb_pkg::mem_ctl_t          mem_ctl;
    logic [PTR_W-1:0]            wr_addr;
    logic [7:0]                  wr_data;
    logic [PTR_W-1:0]            rd_addr;
    logic [7:0]                  rd_data;

    urlb_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .out_buffer_size (out_buffer_size)
    );

    urlb_ram #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    urlb_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .out_buffer_size (out_buffer_size),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mem_ctl         (mem_ctl),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

endmodule
`default_nettype wire

// File: tb/uart_rx_line_buffer_check.sv
// Checker for the UART receive line buffer: line predictor and result scoreboard.
`timescale 1ns / 1ps
module uart_rx_line_buffer_check #(
    parameter int RING_DEPTH = urlb_pkg::RING_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [urlb_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [urlb_pkg::APB_DATA_W-1:0]        pwdata,
    input  logic                                   pready,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // [7:0] rx_byte
    input  logic [0:0]                             s_tuser,   // [0] func
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [7:0]                             m_tdata,   // [7:0] line_char
    input  logic [1:0]                             m_tuser,   // [0] char_valid, [1] line_ready
    input  logic                                   m_tlast,
    output int                                     fail_count,
    output int                                     pending
);

    localparam logic [urlb_pkg::APB_ADDR_W-1:0] SIZE_ADDR = {urlb_pkg::REG_SIZE_IDX, 2'b00};

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       ready;
        logic       last;
    } line_result_t;

    // shadow copy of the ring, pointers and size register
    logic [7:0]   ring_mem [RING_DEPTH];
    int           wr_ptr;
    int           rd_ptr;
    logic [6:0]   dest_size;
    line_result_t line_q[$];

    function automatic int ring_next(input int p);
        return (p == RING_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic logic line_end(input logic [7:0] b);
        return (b == urlb_pkg::CH_LF) || (b == urlb_pkg::CH_CR);
    endfunction

    function automatic line_result_t mk_result(input logic [7:0] ch, input logic valid,
                                               input logic ready, input logic last);
        line_result_t r;
        r.ch    = ch;
        r.valid = valid;
        r.ready = ready;
        r.last  = last;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // store a byte unless only the spare slot is left
    task automatic predict_push(input logic [7:0] b);
        int nx;
        nx = ring_next(wr_ptr);
        if (nx != rd_ptr)
        begin
            ring_mem[wr_ptr] = b;
            wr_ptr = nx;
        end
    endtask

    // walk one line out of the ring and queue the results it gives
    task automatic predict_read();
        line_result_t line_res[$];
        int           keep_limit;
        int           scan;
        int           n;
        logic         found;
        logic [7:0]   b;
        keep_limit = (dest_size > urlb_pkg::SIZE_LIMIT) ? int'(urlb_pkg::SIZE_LIMIT)
                                                        : int'(dest_size);
        found = 1'b0;
        if (keep_limit != 0)
        begin
            for (scan = rd_ptr; scan != wr_ptr && !found; scan = ring_next(scan))
                if (line_end(ring_mem[scan]))
                    found = 1'b1;
        end
        if (!found)
        begin
            line_q.push_back(mk_result(8'h00, 1'b0, 1'b0, 1'b1));
            return;
        end
        while (rd_ptr != wr_ptr)
        begin
            b = ring_mem[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
            if (line_end(b))
                break;
            if (line_res.size() + 1 < keep_limit)
                line_res.push_back(mk_result(b, 1'b1, 1'b1, 1'b0));
        end
        // CRLF, or any other pair of terminators, counts as one line end
        if (rd_ptr != wr_ptr && line_end(ring_mem[rd_ptr]))
            rd_ptr = ring_next(rd_ptr);
        n = line_res.size();
        if (n == 0)
            line_q.push_back(mk_result(8'h00, 1'b0, 1'b1, 1'b1));
        else
        begin
            line_res[n - 1].last = 1'b1;
            foreach (line_res[i])
                line_q.push_back(line_res[i]);
        end
    endtask

    task automatic check_result();
        line_result_t want;
        if (line_q.size() == 0)
        begin
            report_mismatch($sformatf("result with no request pending: data=%h user=%b last=%b",
                                      m_tdata, m_tuser, m_tlast));
            return;
        end
        want = line_q.pop_front();
        if (m_tdata !== want.ch)
            report_mismatch($sformatf("line_char %h, want %h", m_tdata, want.ch));
        if (m_tuser[0] !== want.valid)
            report_mismatch($sformatf("char_valid %b, want %b", m_tuser[0], want.valid));
        if (m_tuser[1] !== want.ready)
            report_mismatch($sformatf("line_ready %b, want %b", m_tuser[1], want.ready));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
    endtask

    // results first: nothing returned on an edge belongs to a request taken on it
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            dest_size  = urlb_pkg::SIZE_RESET;
            fail_count = 0;
            line_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
                dest_size = pwdata[6:0];
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == urlb_pkg::FUNC_READ)
                    predict_read();
                else
                    predict_push(s_tdata);
            end
        end
        pending = line_q.size();
    end

endmodule

// File: tb/uart_rx_line_buffer_test.sv
// Testbench top for the UART receive line buffer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module uart_rx_line_buffer_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 5;
    localparam int FILL_ITEMS  = 258;
    localparam int FILL_CHUNK  = 65;
    localparam logic [urlb_pkg::APB_ADDR_W-1:0] SIZE_ADDR = {urlb_pkg::REG_SIZE_IDX, 2'b00};

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [urlb_pkg::APB_ADDR_W-1:0]  paddr;
    logic [urlb_pkg::APB_DATA_W-1:0]  pwdata;
    logic [urlb_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;
    logic [0:0]                       s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [7:0]                       m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    uart_rx_line_buffer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    uart_rx_line_buffer_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == urlb_pkg::CH_LF || b == urlb_pkg::CH_CR);
        return b;
    endfunction

    // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both
    task automatic set_mode(input int mode);
        case (mode)
            1:       begin sender_idle_pct = 80; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 80; end
            3:       begin sender_idle_pct = 34; recv_stall_pct = 34; end
            default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // one request on the s_ stream, with random idle cycles ahead of it
    task automatic send_request(input logic func, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic read_line();
        send_request(urlb_pkg::FUNC_READ, 8'($urandom_range(0, 255)));
    endtask

    // hold off until every result is back, then let the walk settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_size(input logic [6:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= {25'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int         phase;
        int         idx;
        int         pick;
        logic [6:0] size_val;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = urlb_pkg::FUNC_PUSH;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty ring, CRLF pair, empty line, partial line
        set_mode(0);
        read_line();
        send_request(urlb_pkg::FUNC_PUSH, 8'h00);
        send_request(urlb_pkg::FUNC_PUSH, 8'hFF);
        send_request(urlb_pkg::FUNC_PUSH, 8'h41);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_CR);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        read_line();
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        read_line();
        send_request(urlb_pkg::FUNC_PUSH, 8'h78);
        read_line();
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_CR);
        read_line();
        // LF CR LF: one line, then an empty one, then nothing
        send_request(urlb_pkg::FUNC_PUSH, 8'h55);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_CR);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        read_line();
        read_line();
        read_line();
        // size 1 keeps no characters
        drain();
        write_size(7'd1);
        send_request(urlb_pkg::FUNC_PUSH, 8'hAA);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        read_line();
        // size 0 refuses, oversized size saturates
        drain();
        write_size(7'd0);
        send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        read_line();
        drain();
        write_size(7'd127);
        read_line();
        drain();

        // fill the ring past full: a long first line, then short random lines
        write_size(7'd64);
        for (idx = 0; idx < FILL_ITEMS; idx++)
        begin
            if (idx % FILL_CHUNK == 0)
                set_mode(idx / FILL_CHUNK);
            pick = $urandom_range(0, 15);
            if (idx < FILL_CHUNK || pick > 1)
                send_request(urlb_pkg::FUNC_PUSH, plain_byte());
            else if (pick == 0)
                send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_CR);
            else
                send_request(urlb_pkg::FUNC_PUSH, urlb_pkg::CH_LF);
        end
        drain();

        // pull lines out over sizes and flow-control modes
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       size_val = 7'd64;
                1:       size_val = 7'd2;
                2:       size_val = 7'd0;
                3:       size_val = 7'd127;
                4:       size_val = 7'd1;
                default: size_val = 7'($urandom_range(3, 63));
            endcase
            write_size(size_val);
            set_mode(phase % 4);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_request(urlb_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
                else
                    read_line();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
